// File: rtl/srmu_pkg.sv
// constants, types and arithmetic helpers shared by the seed rekey pipeline
package srmu_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MUL_FIRST    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_SECOND   = 64'h94d049bb133111eb;

  localparam int unsigned SHIFT_FIRST  = 30;
  localparam int unsigned SHIFT_SECOND = 27;
  localparam int unsigned SHIFT_LAST   = 31;

  localparam int unsigned MIX_STAGES   = 5;
  localparam int unsigned UNMIX_STAGES = 5;
  localparam int unsigned NUM_STAGES   = MIX_STAGES + 1 + UNMIX_STAGES;

  // newton iteration for the inverse of an odd constant modulo 2^64
  function automatic logic [63:0] odd_inverse(input logic [63:0] a);
    logic [63:0] r;
    r = 64'd1;
    for (int k = 0; k < 6; k++) begin
      r = r * (64'd2 - a * r);
    end
    return r;
  endfunction

  localparam logic [63:0] MUL_FIRST_INV  = odd_inverse(MUL_FIRST);
  localparam logic [63:0] MUL_SECOND_INV = odd_inverse(MUL_SECOND);

  // partial products of a 64 by 64 multiply, low half only
  typedef struct packed {
    logic [63:0] lo_lo;
    logic [31:0] hi_lo;
    logic [31:0] lo_hi;
  } part_t;

  function automatic part_t mul_parts(input logic [63:0] a, input logic [63:0] c);
    part_t p;
    p.lo_lo = a[31:0] * c[31:0];
    p.hi_lo = a[63:32] * c[31:0];
    p.lo_hi = a[31:0] * c[63:32];
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input part_t p);
    logic [31:0] cross_sum;
    cross_sum = p.hi_lo + p.lo_hi;
    return p.lo_lo + {cross_sum, 32'd0};
  endfunction

endpackage

// File: rtl/seed_rekey_mix_unmix_top.sv
// top level of the seed rekey pipeline: handshake, valid chain and key merge
//
// Usage: one input beat on s_axis carries old_seed, old_id and new_id; one
// output beat on m_axis carries new_seed, the seed whose mixed value equals
// the xor of the mixed old seed, old identity and new identity.
// An accepted input beat reaches m_axis through five stages of forward
// mixing (three lanes side by side), one stage that merges the lanes and
// undoes the last xor-shift, and five stages of inverse mixing, the last
// being the output register. Every 64-bit multiply is split into 32-bit
// partial products in one stage and summed in the next.
// Throughput is one beat per cycle while m_axis_tready is high. A stall on
// m_axis holds the output register; upstream stages keep filling empty
// slots, so s_axis_tready only drops once all 11 stages hold a beat.
// Reset clears every stage valid bit; the payload registers are not reset.
module seed_rekey_mix_unmix_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [191:0]  s_axis_tdata,   // old_seed[63:0], old_id[127:64], new_id[191:128]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata    // new_seed[63:0]
);
  import srmu_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   en;

  logic [63:0] mix_seed;
  logic [63:0] mix_old;
  logic [63:0] mix_new;
  logic [63:0] key;
  logic [63:0] merge;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    en[NUM_STAGES] = m_axis_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  srmu_mix u_mix_seed (
    .clk  (clk),
    .en   (en[MIX_STAGES-1:0]),
    .din  (s_axis_tdata[63:0]),
    .dout (mix_seed)
  );

  srmu_mix u_mix_old (
    .clk  (clk),
    .en   (en[MIX_STAGES-1:0]),
    .din  (s_axis_tdata[127:64]),
    .dout (mix_old)
  );

  srmu_mix u_mix_new (
    .clk  (clk),
    .en   (en[MIX_STAGES-1:0]),
    .din  (s_axis_tdata[191:128]),
    .dout (mix_new)
  );

  // merge lanes and undo the final xor-shift
  always_comb begin
    key = mix_seed ^ mix_old ^ mix_new;
  end

  always_ff @(posedge clk) begin
    if (en[MIX_STAGES]) begin
      merge <= key ^ (key >> SHIFT_LAST) ^ (key >> (2 * SHIFT_LAST));
    end
  end

  srmu_unmix u_unmix (
    .clk  (clk),
    .en   (en[NUM_STAGES-1:MIX_STAGES+1]),
    .din  (merge),
    .dout (m_axis_tdata)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid[NUM_STAGES-1];

  // any empty stage lets a new beat in
  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !(&valid) |-> s_axis_tready)
    else $error("input stalled with an empty stage");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&valid) && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline is full and stalled");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> valid[0])
    else $error("accepted beat lost from first stage");

endmodule

// File: rtl/srmu_mix.sv
// forward finaliser lane, five register stages
module srmu_mix (
  input  logic                                clk,
  input  logic [srmu_pkg::MIX_STAGES-1:0]     en,
  input  logic [63:0]                         din,
  output logic [63:0]                         dout
);
  import srmu_pkg::*;

  logic [63:0] st0;
  part_t       st1;
  logic [63:0] st2;
  part_t       st3;
  logic [63:0] st4;

  logic [63:0] sum_in;
  logic [63:0] prod_a;
  logic [63:0] prod_b;

  always_comb begin
    sum_in = din + GOLDEN_GAMMA;
    prod_a = mul_sum(st1);
    prod_b = mul_sum(st3);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st0 <= sum_in ^ (sum_in >> SHIFT_FIRST);
    end
    if (en[1]) begin
      st1 <= mul_parts(st0, MUL_FIRST);
    end
    if (en[2]) begin
      st2 <= prod_a ^ (prod_a >> SHIFT_SECOND);
    end
    if (en[3]) begin
      st3 <= mul_parts(st2, MUL_SECOND);
    end
    if (en[4]) begin
      st4 <= prod_b ^ (prod_b >> SHIFT_LAST);
    end
  end

  assign dout = st4;

endmodule

// File: rtl/srmu_unmix.sv
// inverse finaliser, five register stages ending in the output register
module srmu_unmix (
  input  logic                                clk,
  input  logic [srmu_pkg::UNMIX_STAGES-1:0]   en,
  input  logic [63:0]                         din,
  output logic [63:0]                         dout
);
  import srmu_pkg::*;

  part_t       st0;
  logic [63:0] st1;
  part_t       st2;
  logic [63:0] st3;
  logic [63:0] st4;

  logic [63:0] prod_a;
  logic [63:0] prod_b;

  always_comb begin
    prod_a = mul_sum(st0);
    prod_b = mul_sum(st2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st0 <= mul_parts(din, MUL_SECOND_INV);
    end
    if (en[1]) begin
      st1 <= prod_a ^ (prod_a >> SHIFT_SECOND) ^ (prod_a >> (2 * SHIFT_SECOND));
    end
    if (en[2]) begin
      st2 <= mul_parts(st1, MUL_FIRST_INV);
    end
    if (en[3]) begin
      st3 <= prod_b ^ (prod_b >> SHIFT_FIRST) ^ (prod_b >> (2 * SHIFT_FIRST));
    end
    if (en[4]) begin
      st4 <= st3 - GOLDEN_GAMMA;
    end
  end

  assign dout = st4;

endmodule
